### hw/rtl/pmc_pkg.sv
package pmc_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_TEST  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register index of the entry limit and its width and reset value.
  localparam logic REG_ENTRY_LIMIT = 1'b0;
  localparam int LIMIT_WIDTH = 11;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 11'd1024;

  // Work an item does as it travels down the chain.
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_TEST = 2'd1,
    OP_ADD  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic        present_flag;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic stored_flag;
    logic dropped;
    logic conflict;
  } out_item_t;

  // Control that travels with an item from cell to cell.
  typedef struct packed {
    op_t  op;
    logic flag;
    logic dropped;
    logic found;
    logic fflag;
  } ctl_t;

endpackage

### hw/rtl/presence_memo_cache.sv
// Presence memo cache: a table of up to CAPACITY keys, each with a one-bit
// flag, held in a chain of CAPACITY cells, one entry per cell. Every item walks
// the whole chain, one cell per cycle while the chain is not stalled, and
// compares its key against each cell on the way; its result is registered at
// the end of the chain. Tests, clears and dropped adds never hold the input;
// an add that searches holds the input until its result leaves the chain,
// because the fill count it may bump decides the next item. A full output
// register that is not being emptied stalls the whole chain.
// The entry limit register (index 0, address 0) may be written at any time the
// block is idle; the effective limit is the smaller of it and CAPACITY.
module presence_memo_cache
  import pmc_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  logic [LIMIT_WIDTH-1:0] entry_limit_r;
  logic                   enabled_r;
  logic [CW-1:0]          count_r;
  logic                   add_busy_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic                   adv;
  logic                   accept;
  logic [LW-1:0]          limit_ext;
  logic [LW-1:0]          lim_eff;
  logic                   at_limit;
  ctl_t                   ctl_in;
  out_item_t              res_nxt;

  logic                   vld_s [0:CAPACITY];
  ctl_t                   ctl_s [0:CAPACITY];
  logic [KEY_WIDTH-1:0]   key_s [0:CAPACITY];
  logic [CW-1:0]          cnt_s [0:CAPACITY];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRY_LIMIT) ?
                  {{(32-LIMIT_WIDTH){1'b0}}, entry_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_ENTRY_LIMIT)) begin
      entry_limit_r <= pwdata[LIMIT_WIDTH-1:0];
    end
  end

  // The chain moves whenever the output register is free or being emptied.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !add_busy_r;
  assign accept   = in_valid && in_ready;

  // Intake decisions from the command, the enable flag, the fill count and the entry limit.
  always_comb begin
    limit_ext      = LW'(entry_limit_r);
    lim_eff        = (limit_ext > CAP_L) ? CAP_L : limit_ext;
    at_limit       = LW'(count_r) >= lim_eff;
    ctl_in         = '0;
    ctl_in.op      = OP_PASS;
    ctl_in.flag    = in_data.present_flag;
    unique case (in_data.command)
      CMD_TEST: begin
        if (enabled_r) ctl_in.op = OP_TEST;
      end
      CMD_ADD: begin
        if (!enabled_r || at_limit) ctl_in.dropped = 1'b1;
        else ctl_in.op = OP_ADD;
      end
      CMD_CLEAR: ctl_in.op = OP_PASS;
      default:   ctl_in.op = OP_PASS;
    endcase
  end

  assign vld_s[0] = accept;
  assign ctl_s[0] = ctl_in;
  assign key_s[0] = in_data.key[KEY_WIDTH-1:0];
  assign cnt_s[0] = count_r;

  // Row of entry cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    pmc_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_WIDTH (CW),
      .INDEX     (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (vld_s[g]),
      .in_ctl  (ctl_s[g]),
      .in_key  (key_s[g]),
      .in_cnt  (cnt_s[g]),
      .out_vld (vld_s[g+1]),
      .out_ctl (ctl_s[g+1]),
      .out_key (key_s[g+1]),
      .out_cnt (cnt_s[g+1])
    );
  end

  // Result of the item leaving the last cell.
  always_comb begin
    res_nxt             = '0;
    res_nxt.hit         = (ctl_s[CAPACITY].op == OP_TEST) && ctl_s[CAPACITY].found;
    res_nxt.stored_flag = res_nxt.hit && ctl_s[CAPACITY].fflag;
    res_nxt.dropped     = (ctl_s[CAPACITY].op == OP_PASS) && ctl_s[CAPACITY].dropped;
    res_nxt.conflict    = (ctl_s[CAPACITY].op == OP_ADD) && ctl_s[CAPACITY].found &&
                          (ctl_s[CAPACITY].fflag != ctl_s[CAPACITY].flag);
  end

  // Table control: enable flag, fill count and the add in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      count_r    <= '0;
      add_busy_r <= 1'b0;
    end else begin
      if (adv && vld_s[CAPACITY] && (ctl_s[CAPACITY].op == OP_ADD)) begin
        add_busy_r <= 1'b0;
        if (!ctl_s[CAPACITY].found) count_r <= count_r + CW'(1);
      end
      if (accept) begin
        if (in_data.command == CMD_TEST) enabled_r <= 1'b1;
        if (in_data.command == CMD_CLEAR) begin
          enabled_r <= 1'b0;
          count_r   <= '0;
        end
        if (ctl_in.op == OP_ADD) add_busy_r <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_s[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/pmc_cell.sv
module pmc_cell
  import pmc_pkg::*;
#(
  parameter int KEY_WIDTH = 64,
  parameter int CNT_WIDTH = 11,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  ctl_t                 in_ctl,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [CNT_WIDTH-1:0] in_cnt,
  output logic                 out_vld,
  output ctl_t                 out_ctl,
  output logic [KEY_WIDTH-1:0] out_key,
  output logic [CNT_WIDTH-1:0] out_cnt
);

  localparam logic [CNT_WIDTH-1:0] MY_INDEX = CNT_WIDTH'(INDEX);

  logic [KEY_WIDTH-1:0] key_r;
  logic                 flag_r;
  logic                 vld_r;
  ctl_t                 ctl_r;
  logic [KEY_WIDTH-1:0] fwd_key_r;
  logic [CNT_WIDTH-1:0] fwd_cnt_r;
  ctl_t                 ctl_nxt;
  logic                 live;
  logic                 match;
  logic                 write_en;

  // The entry is in use when the item's snapshot of the fill count covers it.
  always_comb begin
    live     = in_cnt > MY_INDEX;
    match    = live && (in_ctl.op != OP_PASS) && (key_r == in_key);
    ctl_nxt  = in_ctl;
    if (match && !in_ctl.found) begin
      ctl_nxt.found = 1'b1;
      ctl_nxt.fflag = flag_r;
    end
    // An add that has not matched by the first free entry stores its key there.
    write_en = adv && in_vld && (in_ctl.op == OP_ADD) && !in_ctl.found &&
               (in_cnt == MY_INDEX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r     <= ctl_nxt;
      fwd_key_r <= in_key;
      fwd_cnt_r <= in_cnt;
    end
    if (write_en) begin
      key_r  <= in_key;
      flag_r <= in_ctl.flag;
    end
  end

  assign out_vld = vld_r;
  assign out_ctl = ctl_r;
  assign out_key = fwd_key_r;
  assign out_cnt = fwd_cnt_r;

endmodule

### hw/rtl/pmc_checker.sv
module pmc_checker
  import pmc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // A stalled result item holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A result reports at most one of hit, drop and conflict.
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.hit, out_data.dropped, out_data.conflict}))
    else $error("result reports more than one outcome");

  // A stored flag is only reported on a hit.
  a_flag_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stored_flag |-> out_data.hit)
    else $error("stored flag without a hit");

  // The register port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port not ready");

endmodule

bind presence_memo_cache pmc_checker u_pmc_checker (.*);

### tb/memo_checker.sv
`timescale 1ns / 100ps

// Watches the input, result and register ports of the presence memo cache.
// It keeps its own copy of the table, works out the outcome of every accepted
// item, and compares each result leaving the block with the oldest outcome.
module memo_checker
  import pmc_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          results,
  output int          hits,
  output int          drops,
  output int          conflicts
);

  localparam logic [63:0] KEY_MASK =
    (KEY_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << KEY_WIDTH) - 64'd1);

  // Shadow of the block's table and register.
  logic [LIMIT_WIDTH-1:0] entry_limit;
  bit                     table_on;
  logic [63:0]            slot_key [CAPACITY];
  bit                     slot_flag [CAPACITY];
  int                     fill;

  // Outcomes of accepted items whose results have not left the block yet.
  out_item_t pending_outcomes [$];

  int err_count;
  int result_count;
  int hit_count;
  int drop_count;
  int conflict_count;

  // Bit b of a result item carries field_name[b].
  string field_name [4] = '{"conflict", "dropped", "stored_flag", "hit"};

  // Slots fill from zero in order, so only the first fill slots are searched.
  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < fill; i++) begin
      if (slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one item to the shadow table and returns the result it causes.
  function automatic out_item_t predict_memo_result(in_item_t item);
    out_item_t   res;
    logic [63:0] k;
    int          lim;
    int          slot;
    res  = '0;
    k    = item.key & KEY_MASK;
    lim  = (int'(entry_limit) < CAPACITY) ? int'(entry_limit) : CAPACITY;
    slot = find_key(k);
    case (item.command)
      CMD_TEST: begin
        // A test on a disabled table only turns it on.
        if (!table_on) begin
          table_on = 1'b1;
        end else if (slot >= 0) begin
          res.hit         = 1'b1;
          res.stored_flag = slot_flag[slot];
        end
      end
      CMD_ADD: begin
        // The limit check comes first, so a known key at the limit is dropped.
        if (!table_on || fill >= lim) begin
          res.dropped = 1'b1;
        end else if (slot >= 0) begin
          res.conflict = (slot_flag[slot] != item.present_flag);
        end else if (fill < CAPACITY) begin
          slot_key[fill]  = k;
          slot_flag[fill] = item.present_flag;
          fill++;
        end
      end
      CMD_CLEAR: begin
        table_on = 1'b0;
        fill     = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compares one result item with the oldest outcome, field by field.
  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (pending_outcomes.size() == 0) begin
      err_count++;
      $display("%0t: result %b arrived with no item outstanding", $time, got);
      return;
    end
    want = pending_outcomes.pop_front();
    result_count++;
    hit_count      += want.hit;
    drop_count     += want.dropped;
    conflict_count += want.conflict;
    for (int b = 3; b >= 0; b--) begin
      if (got[b] !== want[b]) begin
        err_count++;
        $display("%0t: %s mismatch, expected %b, got %b",
                 $time, field_name[b], want[b], got[b]);
      end
    end
  endtask

  // Results are taken before new items so that an item never meets itself.
  always @(posedge clk) begin
    if (!rst_n) begin
      entry_limit = LIMIT_RESET;
      table_on    = 1'b0;
      fill        = 0;
      pending_outcomes.delete();
    end else begin
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) pending_outcomes.push_back(predict_memo_result(in_data));
      // Only register index zero exists; other indexes are ignored.
      if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_LIMIT) begin
        entry_limit = pwdata[LIMIT_WIDTH-1:0];
      end
    end
    pending   <= pending_outcomes.size();
    errors    <= err_count;
    results   <= result_count;
    hits      <= hit_count;
    drops     <= drop_count;
    conflicts <= conflict_count;
  end

endmodule

### tb/tb_presence_memo_cache.sv
`timescale 1ns / 100ps

module tb_presence_memo_cache;
  import pmc_pkg::*;

  localparam int CAPACITY     = 1024;
  localparam int KEY_WIDTH    = 64;
  localparam int RANDOM_ITEMS = 1050;
  localparam int POOL_SIZE    = 10;

  // Command value that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Byte addresses of the entry limit and of an index with no register.
  localparam logic [2:0] LIMIT_ADDR = {REG_ENTRY_LIMIT, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  localparam logic [63:0] KEY_LOW  = 64'h0;
  localparam logic [63:0] KEY_HIGH = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KEY_TOP  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_NEAR = 64'hffff_ffff_ffff_fffe;
  localparam logic [63:0] KEY_A    = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] KEY_B    = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] KEY_C    = 64'h0123_4567_89ab_cdee;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int results;
  int hits;
  int drops;
  int conflicts;

  // When set, neither side idles.
  logic steady;
  int   sent;
  int   limit_writes;

  logic [63:0] key_pool [POOL_SIZE];

  presence_memo_cache #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  memo_checker #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending),
    .results   (results),
    .hits      (hits),
    .drops     (drops),
    .conflicts (conflicts)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one item after a random gap and holds it until it is accepted.
  task automatic send_item(logic [1:0] cmd, logic [63:0] key, logic flag);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, key: key, present_flag: flag};
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  // Stops sending and waits until every outstanding result has left.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) limit_writes++;
  endtask

  // Result side: mostly ready, with short and occasional long stalls.
  initial begin
    int r;
    int span;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 8);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        span = $urandom_range(10, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin
    int          r;
    int          phase;
    int          target;
    logic [31:0] limit;
    logic [63:0] key;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    sent         = 0;
    limit_writes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled table after reset: adds drop, clear and the unused code do nothing.
    send_item(CMD_ADD, KEY_LOW, 1'b1);
    send_item(CMD_CLEAR, KEY_HIGH, 1'b1);
    send_item(CMD_UNUSED, KEY_HIGH, 1'b1);
    send_item(CMD_TEST, KEY_HIGH, 1'b0);
    // Store the extreme keys, then look them up along with near misses that differ in one bit.
    send_item(CMD_ADD, KEY_LOW, 1'b1);
    send_item(CMD_ADD, KEY_HIGH, 1'b0);
    send_item(CMD_TEST, KEY_LOW, 1'b0);
    send_item(CMD_TEST, KEY_HIGH, 1'b1);
    send_item(CMD_TEST, KEY_TOP, 1'b0);
    send_item(CMD_TEST, KEY_NEAR, 1'b0);
    // Re-adding a known key: same flag is quiet, the other flag conflicts.
    send_item(CMD_ADD, KEY_LOW, 1'b1);
    send_item(CMD_ADD, KEY_LOW, 1'b0);
    send_item(CMD_TEST, KEY_LOW, 1'b0);
    send_item(CMD_UNUSED, KEY_LOW, 1'b0);
    // Clear disables; the next test only re-enables.
    send_item(CMD_CLEAR, KEY_LOW, 1'b0);
    send_item(CMD_TEST, KEY_LOW, 1'b0);
    send_item(CMD_TEST, KEY_LOW, 1'b0);

    // Small limit, plus a write to an index with no register behind it.
    drain();
    write_reg(LIMIT_ADDR, 32'd2);
    write_reg(SPARE_ADDR, 32'd0);
    send_item(CMD_ADD, KEY_A, 1'b0);
    send_item(CMD_ADD, KEY_B, 1'b1);
    send_item(CMD_ADD, KEY_C, 1'b0);
    send_item(CMD_ADD, KEY_A, 1'b1);
    send_item(CMD_TEST, KEY_C, 1'b0);
    send_item(CMD_TEST, KEY_B, 1'b0);

    // A limit of zero drops every add.
    drain();
    write_reg(LIMIT_ADDR, 32'd0);
    send_item(CMD_ADD, KEY_C, 1'b1);
    send_item(CMD_CLEAR, KEY_C, 1'b1);

    // Random phases, each under its own limit and with its own key pool.
    target = sent + RANDOM_ITEMS;
    phase  = 0;
    while (sent < target) begin
      case (phase)
        0: limit = 32'd2047;
        1: limit = 32'(LIMIT_RESET);
        2: limit = 32'd1025;
        3: limit = 32'd0;
        4: limit = 32'd1;
        default: begin
          if ($urandom_range(0, 3) == 0) limit = $urandom_range(0, 2047);
          else limit = $urandom_range(2, 16);
        end
      endcase
      // Every phase starts with the block fully drained.
      drain();
      write_reg(LIMIT_ADDR, limit);
      if ($urandom_range(0, 3) == 0) write_reg(SPARE_ADDR, $urandom);
      steady <= (phase % 4 == 2);
      // Pairs of pool keys differ in a single bit.
      for (int i = 0; i < POOL_SIZE; i++) begin
        if (i % 2 == 1) key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
        else key_pool[i] = {$urandom, $urandom};
      end
      send_item(CMD_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      send_item(CMD_TEST, key_pool[0], 1'($urandom_range(0, 1)));
      repeat ($urandom_range(50, 120)) begin
        r   = $urandom_range(0, 99);
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 50) begin
          send_item(CMD_TEST, key, 1'($urandom_range(0, 1)));
        end else if (r < 58) begin
          send_item(CMD_TEST, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else if (r < 85) begin
          send_item(CMD_ADD, key, 1'($urandom_range(0, 1)));
        end else if (r < 89) begin
          send_item(CMD_ADD, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else if (r < 95) begin
          // A clear is usually followed at once by the test that re-enables.
          send_item(CMD_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 9) < 7) send_item(CMD_TEST, key, 1'($urandom_range(0, 1)));
        end else begin
          send_item(CMD_UNUSED, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end
      end
      phase++;
    end

    // Each item walks the whole chain, so allow that long for stray results.
    drain();
    steady <= 1'b0;
    repeat (CAPACITY + 16) @(posedge clk);
    $display("Ran %0d items under %0d entry limit settings, from zero to above capacity.",
             sent, limit_writes);
    $display("Results: %0d total, %0d hits, %0d dropped adds, %0d flag conflicts.",
             results, hits, drops, conflicts);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guards against a hang far beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("Timed out with %0d results still outstanding.", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
